// File: hw/rtl/pox_pkg.sv
// shared types, constants and codes for the pulse oximeter heart rate and spo2 block
`timescale 1ns / 1ps
package pox_pkg;

	// field widths
	localparam int IrW    = 18;
	localparam int TimeW  = 32;
	localparam int IntvW  = 16;
	localparam int BeatW  = 3;
	localparam int RateW  = 8;
	localparam int Spo2W  = 7;
	localparam int QualW  = 7;
	localparam int InDataW  = 72;
	localparam int OutDataW = 24;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 18;

	// serial divider sizes
	localparam int NumW  = 23;
	localparam int DenW  = 41;
	localparam int QuoW  = 9;
	localparam int StepW = 4;

	// queue between front and back
	localparam int QueueDepth = 2;
	localparam int PtrW       = $clog2(QueueDepth);
	localparam int CntW       = $clog2(QueueDepth + 1);

	// register indexes
	typedef enum logic [CfgAddrW-1:0] {
		REG_FINGER_THR   = 3'd0,
		REG_RISE_MARGIN  = 3'd1,
		REG_MIN_INTERVAL = 3'd2,
		REG_MAX_INTERVAL = 3'd3,
		REG_BEATS_RATE   = 3'd4,
		REG_BEATS_RESTART = 3'd5
	} reg_idx_t;

	// register reset values
	localparam logic [IrW-1:0]   FINGER_THR_RST   = 18'd50000;
	localparam logic [IrW-1:0]   RISE_MARGIN_RST  = 18'd1000;
	localparam logic [IntvW-1:0] MIN_INTERVAL_RST = 16'd300;
	localparam logic [IntvW-1:0] MAX_INTERVAL_RST = 16'd1500;
	localparam logic [BeatW-1:0] BEATS_RATE_RST   = 3'd3;
	localparam logic [BeatW-1:0] BEATS_RESTART_RST = 3'd5;
	localparam logic [BeatW-1:0] MIN_BEATS        = 3'd2;

	// signal quality grading
	localparam logic [IrW-1:0]   QUAL_LVL_TOP  = 18'd100000;
	localparam logic [IrW-1:0]   QUAL_LVL_HIGH = 18'd80000;
	localparam logic [IrW-1:0]   QUAL_LVL_MID  = 18'd60000;
	localparam logic [QualW-1:0] QUAL_TOP  = 7'd100;
	localparam logic [QualW-1:0] QUAL_HIGH = 7'd80;
	localparam logic [QualW-1:0] QUAL_MID  = 7'd60;
	localparam logic [QualW-1:0] QUAL_LOW  = 7'd40;

	// spo2 mapping
	localparam logic [Spo2W-1:0] SPO2_OFFSET = 7'd110;
	localparam logic [Spo2W-1:0] SPO2_MIN    = 7'd85;
	localparam logic [Spo2W-1:0] SPO2_MAX    = 7'd100;
	localparam logic [4:0]       SPO2_Q_HIGH = 5'd10;
	localparam logic [StepW-1:0] SPO2_STEPS  = 4'd5;

	// heart rate
	localparam int               BPM_SCALE   = 60000;
	localparam logic [RateW-1:0] RATE_SAT    = 8'd255;
	localparam logic [StepW-1:0] RATE_STEPS  = 4'd9;

	typedef struct packed {
		logic [IrW-1:0]   finger_threshold;
		logic [IrW-1:0]   rise_margin;
		logic [IntvW-1:0] min_beat_interval;
		logic [IntvW-1:0] max_beat_interval;
		logic [BeatW-1:0] beats_for_rate;
		logic [BeatW-1:0] beats_before_restart;
	} cfg_t;

	// one classified sample handed from front to back
	typedef struct packed {
		logic             finger;
		logic [IrW-1:0]   red;
		logic [IrW-1:0]   ir;
		logic [QualW-1:0] quality;
		logic             rate_upd;
		logic [BeatW-1:0] beats_m1;
		logic [TimeW-1:0] span;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		logic             start;
		logic [NumW-1:0]  num;
		logic [DenW-1:0]  den;
		logic [StepW-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [QuoW-1:0] quo;
	} div_rsp_t;

endpackage

// File: hw/rtl/pox_fifo.sv
// two-entry command queue between the front and back parts
`timescale 1ns / 1ps
module pox_fifo import pox_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       wr,
	input  logic       pop,
	output cmd_t       rd,
	output fifo_stat_t stat
);

	cmd_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign rd         = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == CntW'(QueueDepth));
	assign stat.empty = (cnt_q == '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/pox_front.sv
// front part: takes samples, tracks peaks and beats, queues one command per sample
`timescale 1ns / 1ps
module pox_front import pox_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [InDataW-1:0] s_tdata,   // ir_sample, red_sample, time_ms
	input  fifo_stat_t         stat,
	output logic               push,
	output cmd_t               cmd
);

	logic [IrW-1:0]   prev_ir_q;
	logic             rising_q;
	logic             peak_seen_q;
	logic [TimeW-1:0] last_peak_q;
	logic [BeatW-1:0] beat_cnt_q;
	logic [TimeW-1:0] first_beat_q;

	logic [IrW-1:0]   ir;
	logic [IrW-1:0]   red;
	logic [TimeW-1:0] now;
	logic             finger;
	logic [IrW:0]     rise_thr;
	logic             rising_n;
	logic             peak;
	logic [TimeW-1:0] interval;
	logic             in_window;
	logic [BeatW-1:0] beat_inc;
	logic [TimeW-1:0] first_eff;
	logic [BeatW-1:0] rate_min;
	logic [BeatW-1:0] restart_min;
	logic             rate_hit;
	logic [QualW-1:0] quality;

	assign ir  = s_tdata[IrW-1:0];
	assign red = s_tdata[2*IrW-1:IrW];
	assign now = s_tdata[2*IrW+TimeW-1:2*IrW];

	assign s_tready = !stat.full;
	assign push     = s_tvalid && !stat.full;

	// rise then fall marks a peak
	always_comb begin
		finger    = (ir >= cfg.finger_threshold);
		rise_thr  = {1'b0, prev_ir_q} + {1'b0, cfg.rise_margin};
		rising_n  = rising_q || ({1'b0, ir} > rise_thr);
		peak      = rising_n && (ir < prev_ir_q);
		interval  = now - last_peak_q;
		in_window = peak_seen_q
			&& (interval > TimeW'(cfg.min_beat_interval))
			&& (interval < TimeW'(cfg.max_beat_interval));
		beat_inc    = beat_cnt_q + 1'b1;
		first_eff   = (beat_cnt_q == '0) ? now : first_beat_q;
		rate_min    = (cfg.beats_for_rate < MIN_BEATS) ? MIN_BEATS : cfg.beats_for_rate;
		restart_min = (cfg.beats_before_restart < MIN_BEATS) ?
			MIN_BEATS : cfg.beats_before_restart;
		rate_hit    = (beat_inc >= rate_min);
	end

	// quality grade by ir level
	always_comb begin
		priority if (ir > QUAL_LVL_TOP) begin
			quality = QUAL_TOP;
		end else if (ir > QUAL_LVL_HIGH) begin
			quality = QUAL_HIGH;
		end else if (ir > QUAL_LVL_MID) begin
			quality = QUAL_MID;
		end else begin
			quality = QUAL_LOW;
		end
	end

	// command word for the back part
	always_comb begin
		cmd.finger   = finger;
		cmd.red      = red;
		cmd.ir       = ir;
		cmd.quality  = quality;
		cmd.rate_upd = finger && peak && in_window && rate_hit;
		cmd.beats_m1 = beat_cnt_q;
		cmd.span     = now - first_eff;
	end

	// peak and beat tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ir_q    <= '0;
			rising_q     <= 1'b0;
			peak_seen_q  <= 1'b0;
			last_peak_q  <= '0;
			beat_cnt_q   <= '0;
			first_beat_q <= '0;
		end else if (push && finger) begin
			prev_ir_q <= ir;
			if (peak) begin
				last_peak_q <= now;
				peak_seen_q <= 1'b1;
				rising_q    <= 1'b0;
				if (in_window) begin
					if (beat_cnt_q == '0) begin
						first_beat_q <= now;
					end
					beat_cnt_q <= (rate_hit && (beat_inc >= restart_min)) ? '0 : beat_inc;
				end
			end else begin
				rising_q <= rising_n;
			end
		end
	end

endmodule

// File: hw/rtl/pox_div.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pox_div import pox_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NumW-1:0]  rem_q;
	logic [DenW-1:0]  den_q;
	logic [QuoW-1:0]  quo_q;
	logic [StepW-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	// divisor is pre-shifted to the top quotient bit
	assign ge = ({{(DenW-NumW){1'b0}}, rem_q} >= den_q);

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q[NumW-1:0];
			end
			den_q <= den_q >> 1;
			quo_q <= {quo_q[QuoW-2:0], ge};
		end
	end

	// step count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hw/rtl/pox_back.sv
// back part: runs the spo2 and rate divisions, keeps the held reading, drives results
`timescale 1ns / 1ps
module pox_back import pox_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                head,
	input  fifo_stat_t          stat,
	output logic                pop,
	output div_req_t            req,
	input  div_rsp_t            rsp,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata   // finger_detected, reading_valid, heart_rate,
	                                      // oxygen_saturation, signal_quality
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SPO2 = 4'b0010,
		ST_RATE = 4'b0100,
		ST_SEND = 4'b1000
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [Spo2W-1:0]     spo2_q;
	logic [RateW-1:0]     rate_q;
	logic [RateW-1:0]     held_rate_q;
	logic                 valid_q;
	logic                 m_tvalid_q;
	logic [OutDataW-1:0]  m_tdata_q;

	logic                 send;
	logic [Spo2W-1:0]     spo2_val;
	logic [4:0]           spo2_quo;
	logic [RateW-1:0]     hr_out;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign send     = (state_q == ST_SEND) && (!m_tvalid_q || m_tready);
	assign spo2_quo = rsp.quo[4:0];
	assign hr_out   = cmd_q.rate_upd ? rate_q : held_rate_q;

	// spo2 from the 25*red/ir quotient, clamped
	always_comb begin
		priority if ((cmd_q.red == '0) || (cmd_q.ir == '0)) begin
			spo2_val = '0;
		end else if (cmd_q.red >= cmd_q.ir) begin
			spo2_val = SPO2_MIN;
		end else if (spo2_quo <= SPO2_Q_HIGH) begin
			spo2_val = SPO2_MAX;
		end else begin
			spo2_val = SPO2_OFFSET - {2'b0, spo2_quo};
		end
	end

	// divider requests and queue pop
	always_comb begin
		pop       = 1'b0;
		req.start = 1'b0;
		req.num   = NumW'({head.red, 4'b0}) + NumW'({head.red, 3'b0}) + NumW'(head.red);
		req.den   = DenW'({head.ir, 4'b0});
		req.steps = SPO2_STEPS;
		unique case (state_q)
			ST_IDLE: begin
				pop       = !stat.empty;
				req.start = !stat.empty && head.finger;
			end
			ST_SPO2: begin
				req.start = rsp.done && cmd_q.rate_upd;
				req.num   = NumW'(cmd_q.beats_m1) * NumW'(BPM_SCALE);
				req.den   = {1'b0, cmd_q.span, 8'b0};
				req.steps = RATE_STEPS;
			end
			ST_RATE, ST_SEND: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!stat.empty) begin
						state_q <= head.finger ? ST_SPO2 : ST_SEND;
					end
				end
				ST_SPO2: begin
					if (rsp.done) begin
						state_q <= cmd_q.rate_upd ? ST_RATE : ST_SEND;
					end
				end
				ST_RATE: begin
					if (rsp.done) begin
						state_q <= ST_SEND;
					end
				end
				ST_SEND: begin
					if (send) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers for the current word
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if ((state_q == ST_SPO2) && rsp.done) begin
			spo2_q <= spo2_val;
		end
		if ((state_q == ST_RATE) && rsp.done) begin
			rate_q <= rsp.quo[QuoW-1] ? RATE_SAT : rsp.quo[RateW-1:0];
		end
		if (send) begin
			if (cmd_q.finger) begin
				m_tdata_q <= {cmd_q.quality, spo2_q, hr_out, (valid_q || cmd_q.rate_upd), 1'b1};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	// held reading and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_rate_q <= '0;
			valid_q     <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (send) begin
				m_tvalid_q <= 1'b1;
				if (!cmd_q.finger) begin
					held_rate_q <= '0;
					valid_q     <= 1'b0;
				end else if (cmd_q.rate_upd) begin
					held_rate_q <= rate_q;
					valid_q     <= 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// File: hw/rtl/pulse_ox_heart_rate_spo2.sv
// top level of the pulse oximeter heart rate and spo2 block
`timescale 1ns / 1ps
// Each input word is one optical sample (ir, red, time in ms); each produces exactly one
// result word in order. The front takes a sample whenever its two-entry queue has room,
// updating the peak and beat tracker at once. The back works one queued sample at a time
// through a shared one-bit-per-cycle divider: 5 divider steps for spo2 if a finger is
// present, 9 more steps for the heart rate if a rate window completes, none without a
// finger. A result held at the output does not stop the front from taking further
// samples until the queue fills. The user must write the configuration registers through
// cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block does not enforce it.
module pulse_ox_heart_rate_spo2 import pox_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // ir_sample, red_sample, time_ms, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata    // finger_detected, reading_valid, heart_rate,
	                                       // oxygen_saturation, signal_quality
);

	cfg_t       cfg_q;
	fifo_stat_t stat;
	cmd_t       cmd_in;
	cmd_t       cmd_head;
	logic       push;
	logic       pop;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.finger_threshold     <= FINGER_THR_RST;
			cfg_q.rise_margin          <= RISE_MARGIN_RST;
			cfg_q.min_beat_interval    <= MIN_INTERVAL_RST;
			cfg_q.max_beat_interval    <= MAX_INTERVAL_RST;
			cfg_q.beats_for_rate       <= BEATS_RATE_RST;
			cfg_q.beats_before_restart <= BEATS_RESTART_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_FINGER_THR:    cfg_q.finger_threshold     <= cfg_wdata[IrW-1:0];
				REG_RISE_MARGIN:   cfg_q.rise_margin          <= cfg_wdata[IrW-1:0];
				REG_MIN_INTERVAL:  cfg_q.min_beat_interval    <= cfg_wdata[IntvW-1:0];
				REG_MAX_INTERVAL:  cfg_q.max_beat_interval    <= cfg_wdata[IntvW-1:0];
				REG_BEATS_RATE:    cfg_q.beats_for_rate       <= cfg_wdata[BeatW-1:0];
				REG_BEATS_RESTART: cfg_q.beats_before_restart <= cfg_wdata[BeatW-1:0];
				default: begin
				end
			endcase
		end
	end

	pox_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.stat     (stat),
		.push     (push),
		.cmd      (cmd_in)
	);

	pox_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr     (cmd_in),
		.pop    (pop),
		.rd     (cmd_head),
		.stat   (stat)
	);

	pox_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pox_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (cmd_head),
		.stat     (stat),
		.pop      (pop),
		.req      (div_req),
		.rsp      (div_rsp),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// no finger means an all-zero word
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[OutDataW-1:1] == '0))
		else $error("no-finger word carries nonzero fields");

	// with a finger spo2 is zero or inside its clamp range
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |->
		((m_tdata[16:10] == '0) ||
		 ((m_tdata[16:10] >= SPO2_MIN) && (m_tdata[16:10] <= SPO2_MAX))))
		else $error("spo2 outside clamp range");

	// with a finger quality is one of the four grades
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |->
		((m_tdata[23:17] == QUAL_TOP) || (m_tdata[23:17] == QUAL_HIGH) ||
		 (m_tdata[23:17] == QUAL_MID) || (m_tdata[23:17] == QUAL_LOW)))
		else $error("signal quality not a valid grade");

	// no reading yet means no heart rate
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |-> (m_tdata[9:2] == '0))
		else $error("heart rate shown without a valid reading");

endmodule

// File: verif/pulse_ox_heart_rate_spo2_tb.sv
// self-checking testbench for the pulse oximeter heart rate and spo2 block
`timescale 1ns / 1ps
module pulse_ox_heart_rate_spo2_tb;
	import pox_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int PhaseCount = 8;

	// one result word, last field in the lowest bit
	typedef struct packed {
		logic [QualW-1:0] quality;
		logic [Spo2W-1:0] spo2;
		logic [RateW-1:0] rate;
		logic             valid;
		logic             finger;
	} reading_t;

	// tracks peaks and beats the way the block should and checks its readings
	class pox_reading_checker;
		logic [IrW-1:0]   thr;
		logic [IrW-1:0]   margin;
		logic [IntvW-1:0] min_gap;
		logic [IntvW-1:0] max_gap;
		logic [BeatW-1:0] beats_rate;
		logic [BeatW-1:0] beats_restart;
		logic [IrW-1:0]   prev_ir;
		bit               rising;
		bit               peak_seen;
		bit               valid;
		logic [TimeW-1:0] last_peak;
		logic [TimeW-1:0] first_beat;
		int unsigned      beats;
		logic [RateW-1:0] held_rate;
		reading_t         expected_readings[$];
		int               mismatches;

		function new();
			thr = 18'd50000;
			margin = 18'd1000;
			min_gap = 16'd300;
			max_gap = 16'd1500;
			beats_rate = 3'd3;
			beats_restart = 3'd5;
			prev_ir = '0;
			rising = 0;
			peak_seen = 0;
			valid = 0;
			last_peak = '0;
			first_beat = '0;
			beats = 0;
			held_rate = '0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CfgDataW-1:0] v);
			case (idx)
				REG_FINGER_THR:    thr = v;
				REG_RISE_MARGIN:   margin = v;
				REG_MIN_INTERVAL:  min_gap = v[IntvW-1:0];
				REG_MAX_INTERVAL:  max_gap = v[IntvW-1:0];
				REG_BEATS_RATE:    beats_rate = v[BeatW-1:0];
				REG_BEATS_RESTART: beats_restart = v[BeatW-1:0];
				default: ;
			endcase
		endfunction

		// beat settings below two act as two
		function int unsigned beats_floor(logic [BeatW-1:0] v);
			return (v < 2) ? 2 : v;
		endfunction

		function logic [Spo2W-1:0] spo2_estimate(logic [IrW-1:0] red, logic [IrW-1:0] ir);
			longint unsigned q;
			if (red == 0 || ir == 0)
				return '0;
			q = (64'(red) * 25) / 64'(ir);
			if (q >= 25)
				return 7'd85;
			if (q <= 10)
				return 7'd100;
			return 7'(110 - q);
		endfunction

		function logic [QualW-1:0] quality_grade(logic [IrW-1:0] ir);
			if (ir > 100000)
				return 7'd100;
			if (ir > 80000)
				return 7'd80;
			if (ir > 60000)
				return 7'd60;
			return 7'd40;
		endfunction

		// a peak closes an interval; intervals inside the window count as beats
		function void register_peak(logic [TimeW-1:0] now);
			logic [TimeW-1:0] gap;
			logic [TimeW-1:0] span;
			int unsigned      r;
			if (peak_seen) begin
				gap = now - last_peak;
				if (gap > min_gap && gap < max_gap) begin
					if (beats == 0)
						first_beat = now;
					beats++;
					if (beats >= beats_floor(beats_rate)) begin
						span = now - first_beat;
						held_rate = 8'd255;
						if (span != 0) begin
							r = ((beats - 1) * 60000) / span;
							held_rate = (r > 255) ? 8'd255 : 8'(r);
						end
						valid = 1;
						if (beats >= beats_floor(beats_restart))
							beats = 0;
					end
				end
			end
			last_peak = now;
			peak_seen = 1;
			rising = 0;
		endfunction

		function void note_sample(logic [IrW-1:0] ir, logic [IrW-1:0] red, logic [TimeW-1:0] now);
			reading_t r;
			r = '0;
			if (ir < thr) begin
				// no finger: held reading dropped, peak tracker left alone
				valid = 0;
				held_rate = '0;
			end else begin
				if (!rising && 32'(ir) > 32'(prev_ir) + 32'(margin))
					rising = 1;
				if (rising && ir < prev_ir)
					register_peak(now);
				prev_ir = ir;
				r.finger = 1'b1;
				r.valid = valid;
				r.rate = held_rate;
				r.spo2 = spo2_estimate(red, ir);
				r.quality = quality_grade(ir);
			end
			expected_readings.push_back(r);
		endfunction

		function void check_reading(logic [OutDataW-1:0] word);
			reading_t got;
			reading_t want;
			got = word;
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h at %0t", word, $realtime);
				return;
			end
			want = expected_readings.pop_front();
			if (got.finger !== want.finger || got.valid !== want.valid ||
			    got.rate !== want.rate || got.spo2 !== want.spo2 ||
			    got.quality !== want.quality) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch at %0t: finger %b/%b valid %b/%b rate %0d/%0d ",
					          "spo2 %0d/%0d quality %0d/%0d (expected/actual)"},
					         $realtime, want.finger, got.finger, want.valid, got.valid,
					         want.rate, got.rate, want.spo2, got.spo2, want.quality, got.quality);
			end
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;

	pox_reading_checker sb;
	bit                 idle_en = 1'b1;
	int                 stall_left = 0;
	int                 cycles = 0;
	int                 items_sent = 0;
	logic [TimeW-1:0]   now_ms = '0;

	pulse_ox_heart_rate_spo2 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result words
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_reading(m_tdata);
	end

	// one sample word, entered and left at a falling edge
	task automatic send_sample(input logic [IrW-1:0] ir, input logic [IrW-1:0] red,
	                           input logic [TimeW-1:0] t);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, t, red, ir};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_sample(ir, red, t);
		items_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every reading is back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() > 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CfgDataW-1:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic apply_config(input int unsigned thr, input int unsigned margin,
	                            input int unsigned mn, input int unsigned mx,
	                            input int unsigned br, input int unsigned bb);
		write_reg(REG_FINGER_THR, CfgDataW'(thr));
		write_reg(REG_RISE_MARGIN, CfgDataW'(margin));
		write_reg(REG_MIN_INTERVAL, CfgDataW'(mn));
		write_reg(REG_MAX_INTERVAL, CfgDataW'(mx));
		write_reg(REG_BEATS_RATE, CfgDataW'(br));
		write_reg(REG_BEATS_RESTART, CfgDataW'(bb));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// red level mostly a plausible fraction of ir, sometimes zero or anything
	function automatic logic [IrW-1:0] pick_red(input int unsigned ir);
		longint unsigned v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = $urandom_range(0, 262143);
			default: v = (longint'(ir) * $urandom_range(20, 130)) / 100;
		endcase
		return (v > 262143) ? 18'h3FFFF : 18'(v);
	endfunction

	// pulse train: low, rise, top, drop; the drop marks the peak
	task automatic beat_train(input int n, input bit in_window);
		int unsigned amp;
		int unsigned lo;
		int unsigned top;
		int unsigned period;
		int unsigned pace;
		int unsigned lo_w;
		int unsigned hi_w;
		int k;
		amp = sb.margin + 1 + $urandom_range(0, 3000);
		if (sb.thr + 2 * amp > 262143)
			amp = (262143 - sb.thr) / 2;
		lo = $urandom_range(sb.thr, 262143 - 2 * amp);
		case ($urandom_range(0, 5))
			0: now_ms = $urandom;
			1: now_ms = 32'hFFFF_FFFF - $urandom_range(0, 5000);
			default: now_ms = now_ms + $urandom_range(1, 100);
		endcase
		for (k = 0; k < n; k++) begin
			if (in_window && sb.max_gap > sb.min_gap + 1) begin
				lo_w = sb.min_gap + 1;
				hi_w = sb.max_gap - 1;
				if ($urandom_range(0, 2) == 0 && hi_w > lo_w + 300)
					hi_w = lo_w + 300;
				period = $urandom_range(lo_w, hi_w);
			end else begin
				period = $urandom_range(0, 70000);
			end
			pace = period / 4;
			top = lo + 2 * amp - $urandom_range(0, amp / 2);
			send_sample(IrW'(lo), pick_red(lo), now_ms + pace);
			send_sample(IrW'(lo + amp), pick_red(lo + amp), now_ms + 2 * pace);
			send_sample(IrW'(top), pick_red(top), now_ms + 3 * pace);
			now_ms = now_ms + period;
			send_sample(IrW'(lo), pick_red(lo), now_ms);
		end
	endtask

	task automatic noise_burst(input int n);
		int unsigned ir;
		int k;
		for (k = 0; k < n; k++) begin
			ir = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 262143);
			now_ms = ($urandom_range(0, 1) == 0) ? $urandom : now_ms + $urandom_range(0, 2000);
			send_sample(IrW'(ir),
			            IrW'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 262143) :
			                                               pick_red(ir)),
			            now_ms);
		end
	endtask

	task automatic no_finger_burst(input int n);
		int unsigned ir;
		int k;
		for (k = 0; k < n; k++) begin
			ir = $urandom_range(0, sb.thr - 1);
			now_ms = now_ms + $urandom_range(1, 50);
			send_sample(IrW'(ir), IrW'($urandom_range(0, 262143)), now_ms);
		end
	endtask

	// extremes, every quality band, spo2 clamps, and a beat run across the time wrap
	task automatic directed();
		logic [TimeW-1:0] t0;
		logic [TimeW-1:0] tb;
		int k;
		t0 = 32'hFFFF_F800;
		send_sample(18'd0, 18'd0, 32'd0);
		send_sample(18'd49999, 18'h3FFFF, 32'hFFFF_FFFF);
		send_sample(18'd50000, 18'd0, 32'd1);
		send_sample(18'd60001, 18'd6000, 32'd2);
		send_sample(18'd80001, 18'd80001, 32'd3);
		send_sample(18'd100001, 18'd68000, 32'd4);
		send_sample(18'h3FFFF, 18'h3FFFF, 32'd5);
		send_sample(18'd100000, 18'd40000, 32'd6);
		for (k = 0; k < 5; k++) begin
			tb = t0 + k * 800;
			send_sample(18'd70000, 18'd35000, tb - 100);
			send_sample(18'd90000, 18'd40000, tb - 50);
			send_sample(18'd72000, 18'd30000, tb);
		end
		send_sample(18'd1000, 18'd500, t0 + 4100);
		now_ms = t0 + 4100;
	endtask

	task automatic phase_config(input int ph);
		case (ph)
			0: apply_config(50000, 1000, 300, 1500, 3, 5);
			1: apply_config(0, 0, 0, 65535, 2, 2);
			2: apply_config(262143, 262143, 65535, 0, 7, 7);
			3: apply_config(30000, 500, 100, 2000, 7, 2);
			4: apply_config(60000, 2000, 200, 1200, 1, 0);
			5: apply_config($urandom_range(20000, 90000), $urandom_range(200, 5000),
			                $urandom_range(100, 600), $urandom_range(800, 3000), 4, 6);
			6: apply_config($urandom_range(20000, 90000), $urandom_range(200, 5000),
			                $urandom_range(100, 600), $urandom_range(800, 3000),
			                $urandom_range(2, 7), $urandom_range(2, 7));
			default: apply_config(50000, 1000, 300, 1500, 3, 5);
		endcase
	endtask

	initial begin
		int budget[PhaseCount];
		int ph;
		int target;
		int pick;
		bit paused;
		budget = '{240, 240, 80, 240, 220, 220, 220, 240};
		paused = 0;
		sb = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		directed();
		drain();
		for (ph = 0; ph < PhaseCount; ph++) begin
			phase_config(ph);
			target = items_sent + budget[ph];
			while (items_sent < target) begin
				idle_en = (ph != PhaseCount - 1) && ($urandom_range(0, 3) != 0);
				pick = $urandom_range(0, 9);
				if (pick <= 5)
					beat_train($urandom_range(3, 8), 1'b1);
				else if (pick == 6)
					beat_train($urandom_range(2, 4), 1'b0);
				else if (pick == 7 || sb.thr == 0)
					noise_burst($urandom_range(1, 5));
				else
					no_finger_burst($urandom_range(1, 4));
				// one pause mid-phase until the block has caught up
				if (ph == 3 && !paused && items_sent > target - budget[ph] / 2) begin
					drain();
					paused = 1;
				end
			end
			drain();
		end
		sb.mismatches += sb.pending();
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: pulse_ox_heart_rate_spo2.f
hw/rtl/pox_pkg.sv
hw/rtl/pox_fifo.sv
hw/rtl/pox_front.sv
hw/rtl/pox_div.sv
hw/rtl/pox_back.sv
hw/rtl/pulse_ox_heart_rate_spo2.sv
verif/pulse_ox_heart_rate_spo2_tb.sv
